[src/matrix3_inverse_cofactor_top_defines.svh]
// Assertion macros for the 3x3 inverse pipeline.
`ifndef MATRIX3_INVERSE_COFACTOR_TOP_DEFINES_SVH
`define MATRIX3_INVERSE_COFACTOR_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define M3I_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define M3I_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/m3i_pkg.sv]
// Types, constants and helpers for the 3x3 inverse pipeline.
package m3i_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int TOL_W  = 31;
    localparam int PROD_W = 2 * DATA_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int DET_W  = DATA_W + COF_W + 3;
    localparam int MAG_W  = DET_W;
    localparam int QB     = DATA_W + 1;        // quotient bits, top one flags overflow
    localparam int N_ENT  = 9;
    localparam int PRE_STG = 9;
    localparam int N_STG  = PRE_STG + QB + 1;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [QB-1:0]            quo_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam mag_t  SAT_HALF = mag_t'(1) << (DATA_W - 1);

    // cofactor k = a[MUL_A]*a[MUL_B] - a[SUB_A]*a[SUB_B]
    localparam logic [3:0] MUL_A [0:N_ENT-1] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] MUL_B [0:N_ENT-1] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] SUB_A [0:N_ENT-1] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] SUB_B [0:N_ENT-1] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // sign and magnitude to a saturated word
    function automatic word_t sat_word(input logic neg, input mag_t mag);
        word_t r;
        if (neg)
        begin
            if (mag > SAT_HALF)
                r = WORD_MIN;
            else
                r = $signed(DATA_W'(~mag[DATA_W-1:0] + 1'b1));
        end
        else
        begin
            if (mag >= SAT_HALF)
                r = WORD_MAX;
            else
                r = $signed(mag[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

[src/matrix3_inverse_cofactor_top.sv]
// 3x3 fixed-point matrix inverse by adjugate over determinant, fully pipelined.
// Within tolerance (rounded |det| <= tol) it outputs the rounded adjugate instead.
// Throughput: one matrix per cycle; busy stays low, the pipe never stalls.
// Depth is set by the 33-stage restoring divider, one quotient bit per stage.
// Reset clears the valid pipe and the tolerance register tol_reg (to 0); data regs are not reset.
`include "matrix3_inverse_cofactor_top_defines.svh"

module matrix3_inverse_cofactor_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [m3i_pkg::TOL_W-1:0]           cfg_data,
    input  logic signed [m3i_pkg::DATA_W-1:0]   a_00,
    input  logic signed [m3i_pkg::DATA_W-1:0]   a_01,
    input  logic signed [m3i_pkg::DATA_W-1:0]   a_02,
    input  logic signed [m3i_pkg::DATA_W-1:0]   a_10,
    input  logic signed [m3i_pkg::DATA_W-1:0]   a_11,
    input  logic signed [m3i_pkg::DATA_W-1:0]   a_12,
    input  logic signed [m3i_pkg::DATA_W-1:0]   a_20,
    input  logic signed [m3i_pkg::DATA_W-1:0]   a_21,
    input  logic signed [m3i_pkg::DATA_W-1:0]   a_22,
    output logic signed [m3i_pkg::DATA_W-1:0]   inv_00,
    output logic signed [m3i_pkg::DATA_W-1:0]   inv_01,
    output logic signed [m3i_pkg::DATA_W-1:0]   inv_02,
    output logic signed [m3i_pkg::DATA_W-1:0]   inv_10,
    output logic signed [m3i_pkg::DATA_W-1:0]   inv_11,
    output logic signed [m3i_pkg::DATA_W-1:0]   inv_12,
    output logic signed [m3i_pkg::DATA_W-1:0]   inv_20,
    output logic signed [m3i_pkg::DATA_W-1:0]   inv_21,
    output logic signed [m3i_pkg::DATA_W-1:0]   inv_22,
    output logic signed [m3i_pkg::DATA_W-1:0]   determinant,
    output logic                                invertible,
    output logic                                done
);
    import m3i_pkg::*;

    logic [N_STG-1:0] valid_reg;
    logic [TOL_W-1:0] tol_reg;

    word_t a_reg [0:N_ENT-1];
    word_t row0_s2_reg [0:2];
    word_t row0_s3_reg [0:2];

    logic signed [PROD_W-1:0] pm_reg [0:N_ENT-1];
    logic signed [PROD_W-1:0] ps_reg [0:N_ENT-1];

    cof_t cof_s3_reg [0:N_ENT-1];
    cof_t cof_s4_reg [0:N_ENT-1];
    cof_t cof_s5_reg [0:N_ENT-1];
    cof_t cof_s6_reg [0:N_ENT-1];

    cof_t ppl_reg [0:2];
    cof_t pph_reg [0:2];
    det_t dt_reg  [0:2];
    det_t det_reg;

    mag_t             dmag_s7_reg;
    logic             dneg_s7_reg;
    logic [COF_W-1:0] cmag_reg [0:N_ENT-1];
    logic [N_ENT-1:0] cneg_s7_reg;

    mag_t             rdet_reg;
    mag_t             num_reg  [0:N_ENT-1];
    mag_t             adjm_reg [0:N_ENT-1];
    mag_t             dmag_s8_reg;
    logic             dneg_s8_reg;
    logic [N_ENT-1:0] cneg_s8_reg;

    // divider pipe: index 0 is loaded from stage 9, index QB is the last step
    mag_t             rem_reg  [0:QB][0:N_ENT-1];
    quo_t             quo_reg  [0:QB][0:N_ENT-1];
    mag_t             dvs_reg  [0:QB];
    logic [N_ENT-1:0] qneg_reg [0:QB];
    logic             invf_reg [0:QB];
    word_t            detw_reg [0:QB];
    word_t            adjw_reg [0:QB][0:N_ENT-1];

    mag_t             rem_next  [0:QB-1][0:N_ENT-1];
    logic             qbit_next [0:QB-1][0:N_ENT-1];

    word_t            inv_reg [0:N_ENT-1];
    word_t            det_out_reg;
    logic             inv_flag_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            tol_reg   <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[N_STG-2:0], start};
            if (cfg_valid && cfg_ready)
                tol_reg <= cfg_data;
        end
    end

    // one restoring step per stage, MSB first
    always_comb
    begin
        for (int j = 0; j < QB; j++)
        begin
            for (int k = 0; k < N_ENT; k++)
            begin
                if ((rem_reg[j][k] >> (QB - 1 - j)) >= dvs_reg[j])
                begin
                    rem_next[j][k]  = rem_reg[j][k] - (dvs_reg[j] << (QB - 1 - j));
                    qbit_next[j][k] = 1'b1;
                end
                else
                begin
                    rem_next[j][k]  = rem_reg[j][k];
                    qbit_next[j][k] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: capture
        a_reg[0] <= a_00;
        a_reg[1] <= a_01;
        a_reg[2] <= a_02;
        a_reg[3] <= a_10;
        a_reg[4] <= a_11;
        a_reg[5] <= a_12;
        a_reg[6] <= a_20;
        a_reg[7] <= a_21;
        a_reg[8] <= a_22;

        // stage 2: 18 products; stage 3: cofactors
        for (int k = 0; k < N_ENT; k++)
        begin
            pm_reg[k]     <= a_reg[MUL_A[k]] * a_reg[MUL_B[k]];
            ps_reg[k]     <= a_reg[SUB_A[k]] * a_reg[SUB_B[k]];
            cof_s3_reg[k] <= COF_W'(pm_reg[k]) - COF_W'(ps_reg[k]);
            cof_s4_reg[k] <= cof_s3_reg[k];
            cof_s5_reg[k] <= cof_s4_reg[k];
            cof_s6_reg[k] <= cof_s5_reg[k];
        end

        // stages 4-6: first-row expansion, cofactor split in low 32 and high 33 bits
        for (int i = 0; i < 3; i++)
        begin
            row0_s2_reg[i] <= a_reg[i];
            row0_s3_reg[i] <= row0_s2_reg[i];
            ppl_reg[i] <= row0_s3_reg[i] *
                          $signed({1'b0, cof_s3_reg[3*i][DATA_W-1:0]});
            pph_reg[i] <= row0_s3_reg[i] *
                          $signed(cof_s3_reg[3*i][COF_W-1:DATA_W]);
            dt_reg[i]  <= (DET_W'(pph_reg[i]) <<< DATA_W) + DET_W'(ppl_reg[i]);
        end
        det_reg <= dt_reg[0] + dt_reg[1] + dt_reg[2];

        // stage 7: magnitudes
        dneg_s7_reg <= det_reg[DET_W-1];
        dmag_s7_reg <= det_reg[DET_W-1] ? mag_t'(-det_reg) : mag_t'(det_reg);
        for (int k = 0; k < N_ENT; k++)
        begin
            cneg_s7_reg[k] <= cof_s6_reg[k][COF_W-1];
            cmag_reg[k]    <= cof_s6_reg[k][COF_W-1] ? -cof_s6_reg[k] : cof_s6_reg[k];
        end

        // stage 8: rounding adds and dividends (half divisor added for nearest)
        rdet_reg    <= (dmag_s7_reg + (mag_t'(1) << (2*FRAC_W - 1))) >> (2*FRAC_W);
        dmag_s8_reg <= dmag_s7_reg;
        dneg_s8_reg <= dneg_s7_reg;
        cneg_s8_reg <= cneg_s7_reg;
        for (int k = 0; k < N_ENT; k++)
        begin
            num_reg[k]  <= (mag_t'(cmag_reg[k]) << (2*FRAC_W)) + (dmag_s7_reg >> 1);
            adjm_reg[k] <= (mag_t'(cmag_reg[k]) + (mag_t'(1) << (FRAC_W - 1))) >> FRAC_W;
        end

        // stage 9: tolerance test and saturation, loads divider head
        invf_reg[0] <= rdet_reg > mag_t'(tol_reg);
        detw_reg[0] <= sat_word(dneg_s8_reg, rdet_reg);
        dvs_reg[0]  <= dmag_s8_reg;
        qneg_reg[0] <= cneg_s8_reg ^ {N_ENT{dneg_s8_reg}};
        for (int k = 0; k < N_ENT; k++)
        begin
            rem_reg[0][k]  <= num_reg[k];
            quo_reg[0][k]  <= '0;
            adjw_reg[0][k] <= sat_word(cneg_s8_reg[k], adjm_reg[k]);
        end

        // divider stages
        for (int j = 0; j < QB; j++)
        begin
            dvs_reg[j+1]  <= dvs_reg[j];
            qneg_reg[j+1] <= qneg_reg[j];
            invf_reg[j+1] <= invf_reg[j];
            detw_reg[j+1] <= detw_reg[j];
            for (int k = 0; k < N_ENT; k++)
            begin
                rem_reg[j+1][k]  <= rem_next[j][k];
                quo_reg[j+1][k]  <= {quo_reg[j][k][QB-2:0], qbit_next[j][k]};
                adjw_reg[j+1][k] <= adjw_reg[j][k];
            end
        end

        // output: overflow bit in the quotient forces saturation; a non-invertible item takes the adjugate
        det_out_reg  <= detw_reg[QB];
        inv_flag_reg <= invf_reg[QB];
        for (int k = 0; k < N_ENT; k++)
        begin
            inv_reg[k] <= invf_reg[QB] ? sat_word(qneg_reg[QB][k], mag_t'(quo_reg[QB][k]))
                                       : adjw_reg[QB][k];
        end
    end

    assign done        = valid_reg[N_STG-1];
    assign inv_00      = inv_reg[0];
    assign inv_01      = inv_reg[1];
    assign inv_02      = inv_reg[2];
    assign inv_10      = inv_reg[3];
    assign inv_11      = inv_reg[4];
    assign inv_12      = inv_reg[5];
    assign inv_20      = inv_reg[6];
    assign inv_21      = inv_reg[7];
    assign inv_22      = inv_reg[8];
    assign determinant = det_out_reg;
    assign invertible  = inv_flag_reg;

    `M3I_ASSERT_IMP(a_done_has_start, done, $past(start, N_STG), "done without matching start")
    `M3I_ASSERT_IMP(a_inv_det_nonzero, done && invertible, determinant != '0, "invertible with zero det")
    `M3I_ASSERT_NXT(a_tol_write, cfg_valid && cfg_ready, tol_reg == $past(cfg_data), "tolerance not written")

endmodule

[dv/matrix3_inverse_cofactor_top_tb.sv]
// Self-checking testbench for the 3x3 fixed-point cofactor inverse pipeline.
`timescale 1ns / 1ps

module matrix3_inverse_cofactor_top_tb;

    import m3i_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        word_t ent [9];
    } matrix_t;

    typedef struct {
        word_t ent [9];
        word_t det;
        logic  invertible;
    } inverse_t;

    class inverse_scoreboard;
        inverse_t         pending [$];
        logic [TOL_W-1:0] tol;
        int               errors;
        int               n_checked;
        int               n_singular;

        function new();
            tol = '0;
            errors = 0;
            n_checked = 0;
            n_singular = 0;
        endfunction

        function wide_t mag(wide_t v);
            return (v < 0) ? -v : v;
        endfunction

        // divide by 2^s, nearest, ties away from zero
        function wide_t round_shift(wide_t v, int s);
            wide_t m;
            wide_t one;
            one = 1;
            m = (mag(v) + (one << (s - 1))) >> s;
            return (v < 0) ? -m : m;
        endfunction

        function word_t saturate(wide_t v);
            wide_t hi;
            wide_t lo;
            hi = 128'sd2147483647;
            lo = -128'sd2147483648;
            if (v > hi)
                return WORD_MAX;
            if (v < lo)
                return WORD_MIN;
            return v[DATA_W-1:0];
        endfunction

        function inverse_t invert(matrix_t m);
            wide_t    a [9];
            wide_t    c [9];
            wide_t    det;
            wide_t    det_r;
            wide_t    dmag;
            wide_t    num;
            wide_t    q;
            wide_t    tol_w;
            inverse_t r;
            for (int k = 0; k < 9; k++)
                a[k] = {{96{m.ent[k][DATA_W-1]}}, m.ent[k]};
            c[0] = a[4] * a[8] - a[5] * a[7];
            c[1] = a[2] * a[7] - a[1] * a[8];
            c[2] = a[1] * a[5] - a[2] * a[4];
            c[3] = a[5] * a[6] - a[3] * a[8];
            c[4] = a[0] * a[8] - a[2] * a[6];
            c[5] = a[2] * a[3] - a[0] * a[5];
            c[6] = a[3] * a[7] - a[4] * a[6];
            c[7] = a[1] * a[6] - a[0] * a[7];
            c[8] = a[0] * a[4] - a[1] * a[3];
            det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
            det_r = round_shift(det, 2 * FRAC_W);
            tol_w = {97'b0, tol};
            r.invertible = mag(det_r) > tol_w;
            dmag = mag(det);
            for (int k = 0; k < 9; k++)
            begin
                if (r.invertible)
                begin
                    num = c[k] <<< (2 * FRAC_W);
                    q = (mag(num) + (dmag >> 1)) / dmag;
                    if ((num < 0) != (det < 0))
                        q = -q;
                    r.ent[k] = saturate(q);
                end
                else
                    r.ent[k] = saturate(round_shift(c[k], FRAC_W));
            end
            r.det = saturate(det_r);
            return r;
        endfunction

        function void note_matrix(matrix_t m);
            pending.push_back(invert(m));
        endfunction

        function void check_inverse(inverse_t got);
            inverse_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with no item outstanding", $realtime);
                errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (!want.invertible)
                n_singular++;
            for (int k = 0; k < 9; k++)
                if (got.ent[k] !== want.ent[k])
                begin
                    $display("%0t: inv_%0d%0d expected %h actual %h", $realtime,
                             k / 3, k % 3, want.ent[k], got.ent[k]);
                    errors++;
                end
            if (got.det !== want.det)
            begin
                $display("%0t: determinant expected %h actual %h", $realtime,
                         want.det, got.det);
                errors++;
            end
            if (got.invertible !== want.invertible)
            begin
                $display("%0t: invertible expected %b actual %b", $realtime,
                         want.invertible, got.invertible);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY  = 42;
    localparam int WD_LIMIT = 5000;
    localparam int N_RANDOM = 1850;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [TOL_W-1:0] cfg_data;
    word_t            a_in [9];
    word_t            inv_out [9];
    word_t            determinant;
    logic             invertible;
    logic             done;

    inverse_scoreboard sb;
    int                idle_pct;
    int                quiet_cycles;
    int                n_sent;

    matrix3_inverse_cofactor_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .a_00        (a_in[0]),
        .a_01        (a_in[1]),
        .a_02        (a_in[2]),
        .a_10        (a_in[3]),
        .a_11        (a_in[4]),
        .a_12        (a_in[5]),
        .a_20        (a_in[6]),
        .a_21        (a_in[7]),
        .a_22        (a_in[8]),
        .inv_00      (inv_out[0]),
        .inv_01      (inv_out[1]),
        .inv_02      (inv_out[2]),
        .inv_10      (inv_out[3]),
        .inv_11      (inv_out[4]),
        .inv_12      (inv_out[5]),
        .inv_20      (inv_out[6]),
        .inv_21      (inv_out[7]),
        .inv_22      (inv_out[8]),
        .determinant (determinant),
        .invertible  (invertible),
        .done        (done)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // item and result capture, plus the stall watchdog
    always @(posedge clk)
    begin
        inverse_t got;
        matrix_t  m;
        logic     seen;
        if (rst_n)
        begin
            seen = 1'b0;
            if (start && !busy)
            begin
                for (int k = 0; k < 9; k++)
                    m.ent[k] = a_in[k];
                sb.note_matrix(m);
                seen = 1'b1;
            end
            if (cfg_valid && cfg_ready)
                seen = 1'b1;
            if (done)
            begin
                for (int k = 0; k < 9; k++)
                    got.ent[k] = inv_out[k];
                got.det = determinant;
                got.invertible = invertible;
                sb.check_inverse(got);
                seen = 1'b1;
            end
            quiet_cycles <= seen ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT)
            begin
                $display("%0t: watchdog expired", $realtime);
                $display("matrix3_inverse_cofactor_top regression: fail");
                $finish;
            end
        end
    end

    task automatic send_matrix(matrix_t m);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        for (int k = 0; k < 9; k++)
            a_in[k] <= m.ent[k];
        do
            @(posedge clk);
        while (busy);
        n_sent++;
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.tol = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic word_t rand_entry();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            3: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            4: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            default: return $signed($urandom_range(0, 512)) - 256;
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t m;
        int      shape;
        for (int k = 0; k < 9; k++)
            m.ent[k] = rand_entry();
        shape = $urandom_range(0, 9);
        if (shape == 0)
            for (int k = 0; k < 3; k++)
                m.ent[6 + k] = m.ent[k];      // repeated row, det zero
        else if (shape == 1)
            for (int k = 0; k < 3; k++)
                m.ent[3 * k + 2] = m.ent[3 * k];  // repeated column
        return m;
    endfunction

    function automatic matrix_t fill(word_t v);
        matrix_t m;
        for (int k = 0; k < 9; k++)
            m.ent[k] = v;
        return m;
    endfunction

    task automatic directed_items();
        matrix_t m;
        m = fill('0);
        send_matrix(m);
        for (int k = 0; k < 9; k++)
            m.ent[k] = (k % 4 == 0) ? 32'sh0001_0000 : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++)
            m.ent[k] = (k % 4 == 0) ? 32'sh0002_0000 : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++)
            m.ent[k] = (k % 4 == 0) ? 32'sh0000_0001 : '0;
        send_matrix(m);
        send_matrix(fill(WORD_MAX));
        send_matrix(fill(WORD_MIN));
        send_matrix(fill(-32'sd1));
        for (int k = 0; k < 9; k++)
            m.ent[k] = (k % 4 == 0) ? WORD_MAX : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++)
            m.ent[k] = (k % 4 == 0) ? WORD_MIN : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++)
            m.ent[k] = (k % 2 == 0) ? WORD_MAX : WORD_MIN;
        send_matrix(m);
        for (int k = 0; k < 9; k++)
            m.ent[k] = (k % 4 == 0) ? 32'sh0000_8000 : '0;   // tie-rounding
        send_matrix(m);
        for (int k = 0; k < 9; k++)
            m.ent[k] = (k % 4 == 0) ? -32'sh0003_0000 : 32'sh0000_4000;
        send_matrix(m);
        for (int k = 0; k < 9; k++)
            m.ent[k] = (k == 2 || k == 4 || k == 6) ? 32'sh0001_0000 : '0;
        send_matrix(m);
        repeat (8)
            send_matrix(rand_matrix());
    endtask

    initial
    begin
        logic [TOL_W-1:0] tols [4];
        int               pcts [4];
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int k = 0; k < 9; k++)
            a_in[k] = '0;
        quiet_cycles = 0;
        n_sent = 0;
        idle_pct = 8;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();     // reset tolerance of zero
        tols[0] = 31'h0001_0000;
        tols[1] = {TOL_W{1'b1}};
        tols[2] = TOL_W'($urandom_range(0, 32'h00ff_ffff));
        tols[3] = '0;
        pcts[0] = 8;
        pcts[1] = 56;
        pcts[2] = 0;
        pcts[3] = 8;
        for (int p = 0; p < 4; p++)
        begin
            write_tolerance(tols[p]);
            idle_pct = pcts[p];
            if (p == 1)
                directed_items();
            for (int i = 0; i < N_RANDOM / 4; i++)
                send_matrix(rand_matrix());
        end
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("covered %0d matrices, %0d checked, %0d singular, four tolerance settings",
                 n_sent, sb.n_checked, sb.n_singular);
        $display("idle mixes of 8, 56 and 0 percent on the input side");
        if (sb.errors == 0)
            $display("matrix3_inverse_cofactor_top regression: pass");
        else
            $display("matrix3_inverse_cofactor_top regression: fail");
        $finish;
    end

endmodule

[matrix3_inverse_cofactor_top.f]
+incdir+src
src/m3i_pkg.sv
src/matrix3_inverse_cofactor_top.sv
dv/matrix3_inverse_cofactor_top_tb.sv
